>>> hw/rtl/plane_phase_audio_encoder_top_defines.svh
// Assertion macros for the plane-phase encoder.
// Define NO_ASSERTIONS to compile them out.
`ifndef PLANE_PHASE_AUDIO_ENCODER_TOP_DEFINES_SVH
`define PLANE_PHASE_AUDIO_ENCODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PPAE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppae assertion failed");
// next-cycle implication
`define PPAE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppae assertion failed");
`else
`define PPAE_ASSERT_IMP(label, ante, cons)
`define PPAE_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/ppae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppae_pkg;

    localparam int DELAY_DEPTH_DEF = 256;

    // CORDIC datapath
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 36;
    localparam int IDX_W        = 5;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 652032874;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_SLOPE   = 3'd4;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SINP,
        ST_SINM,
        ST_XWAIT,
        ST_SINX,
        ST_SCALE,
        ST_WRITE,
        ST_READ,
        ST_PICK,
        ST_CORR_A,
        ST_CORR_B,
        ST_CORR_C,
        ST_CORR_D,
        ST_SQUARE,
        ST_SUM,
        ST_VECT,
        ST_FINISH
    } state_t;

    // command to the shared CORDIC
    typedef struct packed {
        logic                       start;
        logic                       vec;
        logic signed [CORDIC_W-1:0] x0;
        logic signed [CORDIC_W-1:0] y0;
        logic signed [CORDIC_W-1:0] z0;
    } cordic_cmd_t;

    // CORDIC result
    typedef struct packed {
        logic                       done;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } cordic_rsp_t;

    // atan(2^-i) as a 32-bit turn fraction
    function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ppae_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared CORDIC: one micro-rotation per cycle, rotation or vectoring mode.
module ppae_cordic (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ppae_pkg::cordic_cmd_t cmd,
    output ppae_pkg::cordic_rsp_t      rsp
);

    localparam int W = ppae_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic signed [W-1:0] x_next, y_next, z_next;
    logic [ppae_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic vec_reg, vec_next;

    logic signed [W-1:0] dx, dy, at;
    logic up;

    // iteration step
    always_comb
    begin
        dx = y_reg >>> idx_reg;
        dy = x_reg >>> idx_reg;
        at = signed'(W'(ppae_pkg::atan_turn(idx_reg)));
        // rotation steers on z, vectoring on the sign of y
        up = vec_reg ? y_reg[W-1] : !z_reg[W-1];

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        vec_next  = vec_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            x_next    = cmd.x0;
            y_next    = cmd.y0;
            z_next    = cmd.z0;
            vec_next  = cmd.vec;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (up)
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == ppae_pkg::IDX_W'(ppae_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            vec_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
            vec_reg  <= vec_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign rsp.done = done_reg;
    assign rsp.y    = y_reg;
    assign rsp.z    = z_reg;

endmodule

`default_nettype wire

>>> hw/rtl/plane_phase_audio_encoder_top.sv
// Plane-phase audio encoder. One sample word in gives one result word out.
// A new sample is taken only after the previous result has moved to the
// output register. The single shared CORDIC makes four 24-step passes per
// sample (y plus sine, y minus sine, x sine, then atan2 for the angle). The
// other states handle the accept, scaling, the ring write and read, the
// pick of the delayed or direct y, the y correction (CORR_A to CORR_D),
// squaring, the magnitude sum and the hand-off to the output register. The
// block-position divide and the magnitude square root run beside the CORDIC
// and add no time. The y delay ring is a one-port memory written in the
// WRITE state and read in the READ state that follows. A finished result
// waits in the output register while the next sample is taken; if that
// register is still full when the next result is done, the block holds
// until the result word is taken. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "plane_phase_audio_encoder_top_defines.svh"

module plane_phase_audio_encoder_top #(
    parameter int DELAY_DEPTH = ppae_pkg::DELAY_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [ppae_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data,
    // sample channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [15:0]             sample_in,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [15:0]                  x_out,
    output logic signed [15:0]                  y_plus_out,
    output logic signed [15:0]                  y_minus_out,
    output logic [15:0]                         magnitude_out,
    output logic signed [15:0]                  angle_out,
    output logic                                compensated
);

    localparam int W  = ppae_pkg::CORDIC_W;
    localparam int PW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int FW = $clog2(DELAY_DEPTH + 1);
    localparam int DW = (FW > 8) ? FW : 8;
    localparam int AW = DW + 1;

    localparam logic signed [W-1:0] RND15 = 16384;

    // ------------------------------------------------------------------
    // helpers
    function automatic logic signed [15:0] clamp16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sd32767;
        else if (v < -64'sd32768)
            r = -16'sd32768;
        else
            r = v[15:0];
        return r;
    endfunction

    // fold a phase into the right half plane for rotation
    function automatic logic signed [W-1:0] rot_z(input logic [31:0] ph);
        logic [31:0] p;
        p = ph;
        if (((ph + 32'h40000000) & 32'h80000000) != 32'h0)
            p = 32'h80000000 - ph;
        return W'(signed'(p));
    endfunction

    // sample offset: sample / 4 turn
    function automatic logic [31:0] samp_off(input logic signed [15:0] s);
        return {s[15], s, 15'b0};
    endfunction

    // ------------------------------------------------------------------
    // registers
    ppae_pkg::state_t state_reg, state_next;

    logic [31:0] phase_step_reg;
    logic [15:0] block_length_reg;
    logic [7:0]  delay_length_reg;
    logic [15:0] out_gain_reg;
    logic [15:0] edge_slope_reg;

    logic [31:0]   acc_reg, acc_next;
    logic [15:0]   bidx_reg, bidx_next;
    logic [15:0]   bi_reg, bi_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          rdy_reg, rdy_next;

    logic signed [15:0] sample_reg, sample_next;
    logic [15:0]        f_reg, f_next;
    logic signed [15:0] sinp_reg, sinp_next;
    logic signed [15:0] sinm_reg, sinm_next;
    logic signed [15:0] xs_reg, xs_next;
    logic signed [15:0] sp_reg, sp_next;
    logic signed [15:0] sm_reg, sm_next;

    logic [31:0] q_reg, q_next;
    logic [15:0] rem_reg, rem_next;
    logic [5:0]  dcnt_reg, dcnt_next;

    logic [31:0] ring_mem [DELAY_DEPTH];
    logic [31:0] rd_data_reg;
    logic        rd_ok_reg, rd_ok_next;
    logic        comp_reg, comp_next;

    logic signed [15:0] vp_reg, vp_next, vm_reg, vm_next;
    logic [15:0]        ap_reg, ap_next, am_reg, am_next;
    logic signed [31:0] pp_reg, pp_next, pm_reg, pm_next;
    logic signed [47:0] gp_reg, gp_next, gm_reg, gm_next;
    logic signed [15:0] yp_reg, yp_next, ym_reg, ym_next;

    logic [31:0] sqx_reg, sqx_next, sqy_reg, sqy_next, sqz_reg, sqz_next;
    logic        zero_reg, zero_next;
    logic [31:0] sv_reg, sv_next, sr_reg, sr_next, sbit_reg, sbit_next;
    logic [15:0] ang_reg, ang_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] x_out_reg, x_out_next;
    logic signed [15:0] yp_out_reg, yp_out_next;
    logic signed [15:0] ym_out_reg, ym_out_next;
    logic [15:0]        mag_out_reg, mag_out_next;
    logic [15:0]        ang_out_reg, ang_out_next;
    logic               comp_out_reg, comp_out_next;

    ppae_pkg::cordic_cmd_t ccmd;
    ppae_pkg::cordic_rsp_t crsp;

    // derived configuration
    logic [15:0]   n_len;
    logic [DW-1:0] d_len;
    logic [PW-1:0] rd_addr;
    logic          mem_we, mem_re;
    logic          accept, load_out;
    logic          cordic_phase;
    logic signed [15:0] sin_val;

    ppae_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ccmd),
        .rsp   (crsp)
    );

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ppae_pkg::ST_IDLE);
    assign load_out = (state_reg == ppae_pkg::ST_FINISH) && (!out_valid_reg || out_ready);
    assign mem_we   = (state_reg == ppae_pkg::ST_WRITE);
    assign mem_re   = (state_reg == ppae_pkg::ST_READ);

    // states that wait on a CORDIC pass
    assign cordic_phase = (state_reg == ppae_pkg::ST_SINP) || (state_reg == ppae_pkg::ST_SINM)
                       || (state_reg == ppae_pkg::ST_SINX) || (state_reg == ppae_pkg::ST_VECT);

    // sine from the CORDIC y word, rounded to Q1.15
    always_comb
    begin
        logic signed [W-1:0] t;
        t = (crsp.y + RND15) >>> 15;
        sin_val = clamp16(64'(t));
    end

    // block length and delay with their edge cases
    always_comb
    begin
        logic [DW-1:0] dl;
        n_len = (block_length_reg == 16'd0) ? 16'd1 : block_length_reg;
        dl = (delay_length_reg == 8'd0) ? DW'(1) : DW'(delay_length_reg);
        d_len = (dl > DW'(DELAY_DEPTH)) ? DW'(DELAY_DEPTH) : dl;
    end

    // delayed read address, write pointer already advanced
    always_comb
    begin
        logic [AW-1:0] t;
        t = AW'(wp_reg) + AW'(DELAY_DEPTH) - AW'(d_len);
        if (t >= AW'(DELAY_DEPTH))
            t = t - AW'(DELAY_DEPTH);
        rd_addr = t[PW-1:0];
    end

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppae_pkg::ST_IDLE:   if (in_valid) state_next = ppae_pkg::ST_SINP;
            ppae_pkg::ST_SINP:   if (crsp.done) state_next = ppae_pkg::ST_SINM;
            ppae_pkg::ST_SINM:   if (crsp.done) state_next = ppae_pkg::ST_XWAIT;
            ppae_pkg::ST_XWAIT:  if (dcnt_reg == 6'd0) state_next = ppae_pkg::ST_SINX;
            ppae_pkg::ST_SINX:   if (crsp.done) state_next = ppae_pkg::ST_SCALE;
            ppae_pkg::ST_SCALE:  state_next = ppae_pkg::ST_WRITE;
            ppae_pkg::ST_WRITE:  state_next = ppae_pkg::ST_READ;
            ppae_pkg::ST_READ:   state_next = ppae_pkg::ST_PICK;
            ppae_pkg::ST_PICK:   state_next = ppae_pkg::ST_CORR_A;
            ppae_pkg::ST_CORR_A: state_next = ppae_pkg::ST_CORR_B;
            ppae_pkg::ST_CORR_B: state_next = ppae_pkg::ST_CORR_C;
            ppae_pkg::ST_CORR_C: state_next = ppae_pkg::ST_CORR_D;
            ppae_pkg::ST_CORR_D: state_next = ppae_pkg::ST_SQUARE;
            ppae_pkg::ST_SQUARE: state_next = ppae_pkg::ST_SUM;
            ppae_pkg::ST_SUM:    state_next = ppae_pkg::ST_VECT;
            ppae_pkg::ST_VECT:   if (crsp.done) state_next = ppae_pkg::ST_FINISH;
            ppae_pkg::ST_FINISH: if (load_out) state_next = ppae_pkg::ST_IDLE;
            default:             state_next = ppae_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs
    always_comb
    begin
        logic [15:0]        mag_in;
        logic [32:0]        fprod;
        logic [16:0]        rem2;
        logic signed [33:0] prod_p, prod_m;
        logic [15:0]        mag_p, mag_m;
        logic [29:0]        lp, lm;
        logic signed [47:0] prm;
        logic signed [47:0] tp, tm;
        logic signed [31:0] x32, yp32, ym32;
        logic signed [16:0] yv;
        logic signed [W-1:0] vx, vy;
        logic [31:0]        uz, rb;
        logic [PW-1:0]      wp_inc;
        logic [FW-1:0]      fill_inc;
        logic [16:0]        bnext;

        mag_in   = '0;
        fprod    = '0;
        rem2     = '0;
        prod_p   = '0;
        prod_m   = '0;
        mag_p    = '0;
        mag_m    = '0;
        lp       = '0;
        lm       = '0;
        prm      = '0;
        tp       = '0;
        tm       = '0;
        x32      = '0;
        yp32     = '0;
        ym32     = '0;
        yv       = '0;
        vx       = '0;
        vy       = '0;
        uz       = '0;
        rb       = '0;
        wp_inc   = '0;
        fill_inc = '0;
        bnext    = '0;

        ccmd.start = 1'b0;
        ccmd.vec   = 1'b0;
        ccmd.x0    = ppae_pkg::CORDIC_GAIN_INV;
        ccmd.y0    = '0;
        ccmd.z0    = '0;

        acc_next    = acc_reg;
        bidx_next   = bidx_reg;
        bi_next     = bi_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        rdy_next    = rdy_reg;
        sample_next = sample_reg;
        f_next      = f_reg;
        sinp_next   = sinp_reg;
        sinm_next   = sinm_reg;
        xs_next     = xs_reg;
        sp_next     = sp_reg;
        sm_next     = sm_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        rd_ok_next  = rd_ok_reg;
        comp_next   = comp_reg;
        vp_next     = vp_reg;
        vm_next     = vm_reg;
        ap_next     = ap_reg;
        am_next     = am_reg;
        pp_next     = pp_reg;
        pm_next     = pm_reg;
        gp_next     = gp_reg;
        gm_next     = gm_reg;
        yp_next     = yp_reg;
        ym_next     = ym_reg;
        sqx_next    = sqx_reg;
        sqy_next    = sqy_reg;
        sqz_next    = sqz_reg;
        zero_next   = zero_reg;
        sv_next     = sv_reg;
        sr_next     = sr_reg;
        sbit_next   = sbit_reg;
        ang_next    = ang_reg;

        out_valid_next = out_valid_reg;
        x_out_next     = x_out_reg;
        yp_out_next    = yp_out_reg;
        ym_out_next    = ym_out_reg;
        mag_out_next   = mag_out_reg;
        ang_out_next   = ang_out_reg;
        comp_out_next  = comp_out_reg;

        // block position divider, one quotient bit per cycle
        if (dcnt_reg != 6'd0)
        begin
            rem2 = {rem_reg, 1'b0};
            if (rem2 >= {1'b0, n_len})
            begin
                rem_next = 16'(rem2 - {1'b0, n_len});
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem2[15:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            dcnt_next = dcnt_reg - 6'd1;
        end

        // square root, one result bit per cycle
        if (sbit_reg != 32'd0)
        begin
            rb = sr_reg + sbit_reg;
            if (sv_reg >= rb)
            begin
                sv_next = sv_reg - rb;
                sr_next = (sr_reg >> 1) + sbit_reg;
            end
            else
            begin
                sr_next = sr_reg >> 1;
            end
            sbit_next = sbit_reg >> 2;
        end

        // drain the output register
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ppae_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next = sample_in;
                    mag_in = sample_in[15] ? 16'(-sample_in) : sample_in;
                    fprod  = 33'(edge_slope_reg) * 33'(mag_in) + 33'd32768;
                    f_next = 16'(17'd32768 - fprod[32:16]);
                    bi_next   = (bidx_reg >= n_len) ? 16'd0 : bidx_reg;
                    rem_next  = (bidx_reg >= n_len) ? 16'd0 : bidx_reg;
                    q_next    = '0;
                    dcnt_next = 6'd32;
                    ccmd.start = 1'b1;
                    ccmd.z0    = rot_z(acc_reg + samp_off(sample_in));
                end
            end
            ppae_pkg::ST_SINP:
            begin
                if (crsp.done)
                begin
                    sinp_next  = sin_val;
                    ccmd.start = 1'b1;
                    ccmd.z0    = rot_z(acc_reg - samp_off(sample_reg));
                end
            end
            ppae_pkg::ST_SINM:
            begin
                if (crsp.done)
                    sinm_next = sin_val;
            end
            ppae_pkg::ST_XWAIT:
            begin
                if (dcnt_reg == 6'd0)
                begin
                    ccmd.start = 1'b1;
                    ccmd.z0    = rot_z(acc_reg + q_reg - 32'h80000000);
                end
            end
            ppae_pkg::ST_SINX:
            begin
                if (crsp.done)
                    xs_next = sin_val;
            end
            ppae_pkg::ST_SCALE:
            begin
                prod_p  = 34'(sinp_reg) * 34'(signed'({1'b0, f_reg}));
                prod_m  = 34'(sinm_reg) * 34'(signed'({1'b0, f_reg}));
                sp_next = clamp16(64'((prod_p + 34'sd16384) >>> 15));
                sm_next = clamp16(64'((prod_m + 34'sd16384) >>> 15));
            end
            ppae_pkg::ST_WRITE:
            begin
                // ring entry written this cycle at wp_reg
                wp_inc   = (wp_reg == PW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                fill_inc = (fill_reg < FW'(DELAY_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
                wp_next   = wp_inc;
                fill_next = fill_inc;
                if (DW'(fill_inc) >= d_len)
                    rdy_next = 1'b1;
            end
            ppae_pkg::ST_READ:
            begin
                comp_next  = rdy_reg;
                rd_ok_next = (d_len <= DW'(fill_reg));
            end
            ppae_pkg::ST_PICK:
            begin
                if (comp_reg)
                begin
                    vp_next = rd_ok_reg ? signed'(rd_data_reg[31:16]) : 16'sd0;
                    vm_next = rd_ok_reg ? signed'(rd_data_reg[15:0]) : 16'sd0;
                end
                else
                begin
                    vp_next = sp_reg;
                    vm_next = sm_reg;
                end
            end
            ppae_pkg::ST_CORR_A:
            begin
                mag_p   = vp_reg[15] ? 16'(-vp_reg) : vp_reg;
                mag_m   = vm_reg[15] ? 16'(-vm_reg) : vm_reg;
                lp      = 30'(mag_p) * 30'd6554 + 30'd32768;
                lm      = 30'(mag_m) * 30'd6554 + 30'd32768;
                ap_next = 16'(17'd32768 - 17'(lp[29:16]));
                am_next = 16'(17'd32768 - 17'(lm[29:16]));
            end
            ppae_pkg::ST_CORR_B:
            begin
                pp_next = 32'(vp_reg) * 32'(signed'({1'b0, ap_reg}));
                pm_next = 32'(vm_reg) * 32'(signed'({1'b0, am_reg}));
            end
            ppae_pkg::ST_CORR_C:
            begin
                gp_next = 48'(pp_reg) * 48'(signed'({1'b0, out_gain_reg}));
                prm     = 48'(pm_reg) * 48'(signed'({1'b0, out_gain_reg}));
                gm_next = -prm;
            end
            ppae_pkg::ST_CORR_D:
            begin
                tp = (gp_reg + 48'sd536870912) >>> 30;
                tm = (gm_reg + 48'sd536870912) >>> 30;
                yp_next = clamp16(64'(tp));
                ym_next = clamp16(64'(tm));
            end
            ppae_pkg::ST_SQUARE:
            begin
                x32  = 32'(xs_reg);
                yp32 = 32'(yp_reg);
                ym32 = 32'(ym_reg);
                sqx_next = unsigned'(x32 * x32);
                sqy_next = unsigned'(yp32 * yp32);
                sqz_next = unsigned'(ym32 * ym32);
                // atan2 of (yp + ym, x) on the CORDIC in vectoring mode
                yv = 17'(yp_reg) + 17'(ym_reg);
                zero_next = (xs_reg == 16'sd0) && (yv == 17'sd0);
                vx = W'(xs_reg);
                vy = W'(yv);
                vx = vx <<< 14;
                vy = vy <<< 14;
                ccmd.start = 1'b1;
                ccmd.vec   = 1'b1;
                ccmd.x0    = vx;
                ccmd.y0    = vy;
                ccmd.z0    = '0;
                if (vx[W-1])
                begin
                    if (!vy[W-1])
                    begin
                        ccmd.x0 = vy;
                        ccmd.y0 = -vx;
                        ccmd.z0 = W'(32'sh40000000);
                    end
                    else
                    begin
                        ccmd.x0 = -vy;
                        ccmd.y0 = vx;
                        ccmd.z0 = -W'(32'sh40000000);
                    end
                end
            end
            ppae_pkg::ST_SUM:
            begin
                sv_next   = sqx_reg + sqy_reg + sqz_reg;
                sr_next   = '0;
                sbit_next = 32'h40000000;
            end
            ppae_pkg::ST_VECT:
            begin
                if (crsp.done)
                begin
                    uz = crsp.z[31:0] + 32'h00008000;
                    ang_next = zero_reg ? 16'd0 : uz[31:16];
                end
            end
            ppae_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    x_out_next     = xs_reg;
                    yp_out_next    = yp_reg;
                    ym_out_next    = ym_reg;
                    mag_out_next   = sr_reg[15:0];
                    ang_out_next   = ang_reg;
                    comp_out_next  = comp_reg;
                    bnext     = 17'(bi_reg) + 17'd1;
                    bidx_next = (bnext >= 17'(n_len)) ? 16'd0 : bnext[15:0];
                    acc_next  = acc_reg + phase_step_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= 32'd118111601;
            block_length_reg <= 16'd1024;
            delay_length_reg <= 8'd80;
            out_gain_reg     <= 16'd32768;
            edge_slope_reg   <= 16'd4369;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ppae_pkg::REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                ppae_pkg::REG_BLOCK_LENGTH: block_length_reg <= cfg_data[15:0];
                ppae_pkg::REG_DELAY_LENGTH: delay_length_reg <= cfg_data[7:0];
                ppae_pkg::REG_OUT_GAIN:     out_gain_reg     <= cfg_data[15:0];
                ppae_pkg::REG_EDGE_SLOPE:   edge_slope_reg   <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppae_pkg::ST_IDLE;
            acc_reg       <= '0;
            bidx_reg      <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            rdy_reg       <= 1'b0;
            dcnt_reg      <= '0;
            sbit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            bidx_reg      <= bidx_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            rdy_reg       <= rdy_next;
            dcnt_reg      <= dcnt_next;
            sbit_reg      <= sbit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        bi_reg       <= bi_next;
        sample_reg   <= sample_next;
        f_reg        <= f_next;
        sinp_reg     <= sinp_next;
        sinm_reg     <= sinm_next;
        xs_reg       <= xs_next;
        sp_reg       <= sp_next;
        sm_reg       <= sm_next;
        q_reg        <= q_next;
        rem_reg      <= rem_next;
        rd_ok_reg    <= rd_ok_next;
        comp_reg     <= comp_next;
        vp_reg       <= vp_next;
        vm_reg       <= vm_next;
        ap_reg       <= ap_next;
        am_reg       <= am_next;
        pp_reg       <= pp_next;
        pm_reg       <= pm_next;
        gp_reg       <= gp_next;
        gm_reg       <= gm_next;
        yp_reg       <= yp_next;
        ym_reg       <= ym_next;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        sqz_reg      <= sqz_next;
        zero_reg     <= zero_next;
        sv_reg       <= sv_next;
        sr_reg       <= sr_next;
        ang_reg      <= ang_next;
        x_out_reg    <= x_out_next;
        yp_out_reg   <= yp_out_next;
        ym_out_reg   <= ym_out_next;
        mag_out_reg  <= mag_out_next;
        ang_out_reg  <= ang_out_next;
        comp_out_reg <= comp_out_next;
    end

    // y delay ring: plus in the upper half, minus in the lower
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[wp_reg] <= {sp_reg, sm_reg};
        if (mem_re)
            rd_data_reg <= ring_mem[rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign x_out         = x_out_reg;
    assign y_plus_out    = yp_out_reg;
    assign y_minus_out   = ym_out_reg;
    assign magnitude_out = mag_out_reg;
    assign angle_out     = signed'(ang_out_reg);
    assign compensated   = comp_out_reg;

    // ------------------------------------------------------------------
    // checks
    `PPAE_ASSERT_NXT(a_busy_after_accept, accept, state_reg != ppae_pkg::ST_IDLE)
    `PPAE_ASSERT_IMP(a_sqrt_before_angle, state_reg == ppae_pkg::ST_VECT && crsp.done, sbit_reg == '0)
    `PPAE_ASSERT_IMP(a_done_expected, crsp.done, cordic_phase)
    `PPAE_ASSERT_IMP(a_comp_sticky, out_valid_reg && comp_out_reg, rdy_reg)

endmodule

`default_nettype wire
